FILE: hw/rtl/lses_pkg.sv
// Shared types, codes and constants for the LED strip effect sequencer.
`default_nettype none

package lses_pkg;

	// Parameter defaults
	localparam int unsigned LED_MAX_DEF     = 1024;
	localparam int unsigned GLOW_LEVELS_DEF = 100;

	// Field and state widths
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned FX_W      = 4;
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned LEN_W     = 11;
	localparam int unsigned PIX_W     = 10;
	localparam int unsigned PHASE_W   = 9;
	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CHAN_W    = 8;

	// Glow scaling: level in 8 bits, factor = ceil(level * 2^SHIFT / levels)
	localparam int unsigned LEVEL_W     = 8;
	localparam int unsigned LEVEL_N     = 2 ** LEVEL_W;
	localparam int unsigned SCALE_SHIFT = 17;
	localparam int unsigned FACT_W      = SCALE_SHIFT + 1;

	// Request types
	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EFFECT  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_COLOR1  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_COLOR2  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LENGTH  = 3'd4;

	// Effect codes; codes above FX_PONG are stored but do nothing
	localparam logic [FX_W-1:0] FX_IDLE   = 4'd0;
	localparam logic [FX_W-1:0] FX_FILL   = 4'd1;
	localparam logic [FX_W-1:0] FX_BLINK  = 4'd2;
	localparam logic [FX_W-1:0] FX_FAST   = 4'd3;
	localparam logic [FX_W-1:0] FX_FLASH  = 4'd4;
	localparam logic [FX_W-1:0] FX_DOUBLE = 4'd5;
	localparam logic [FX_W-1:0] FX_GLOW   = 4'd6;
	localparam logic [FX_W-1:0] FX_FWD    = 4'd7;
	localparam logic [FX_W-1:0] FX_BACK   = 4'd8;
	localparam logic [FX_W-1:0] FX_PONG   = 4'd9;

	// Frame kinds
	localparam logic KIND_FILL  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TIME   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_PAUSE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GLOW_PERIOD   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_PERIOD    = 3'd7;

	// Configuration reset values
	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST  = 16'd500;
	localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 16'd100;
	localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST  = 16'd100;
	localparam logic [CNT_W-1:0]    FLASH_COUNT_RST   = 8'd3;
	localparam logic [PERIOD_W-1:0] DOUBLE_TIME_RST   = 16'd100;
	localparam logic [PERIOD_W-1:0] DOUBLE_PAUSE_RST  = 16'd1000;
	localparam logic [PERIOD_W-1:0] GLOW_PERIOD_RST   = 16'd10;
	localparam logic [PERIOD_W-1:0] RUN_PERIOD_RST    = 16'd50;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [FX_W-1:0]    effect_code;
		logic [COLOR_W-1:0] color_value;
		logic [LEN_W-1:0]   strip_length;
	} in_item_t;

	typedef struct packed {
		logic               frame_kind;
		logic [COLOR_W-1:0] frame_color;
		logic [PIX_W-1:0]   pixel_index;
	} out_item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] blink_period;
		logic [PERIOD_W-1:0] fast_blink_period;
		logic [PERIOD_W-1:0] flash_period;
		logic [CNT_W-1:0]    flash_count;
		logic [PERIOD_W-1:0] double_blink_time;
		logic [PERIOD_W-1:0] double_blink_pause;
		logic [PERIOD_W-1:0] glow_step_period;
		logic [PERIOD_W-1:0] run_step_period;
	} cfg_regs_t;

	// Frame before glow scaling
	typedef struct packed {
		out_item_t          frame;
		logic               glow;
		logic [LEVEL_W-1:0] level;
	} res_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic [FX_W-1:0]  effect;
		logic [LEN_W-1:0] total;
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lses_cfg.sv
// Configuration register file for the LED strip effect sequencer.
`default_nettype none

module lses_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [lses_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [lses_pkg::PERIOD_W-1:0]       wr_data,
	output lses_pkg::cfg_regs_t                      regs
);

	lses_pkg::cfg_regs_t regs_q;

	assign regs = regs_q;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.blink_period       <= lses_pkg::BLINK_PERIOD_RST;
			regs_q.fast_blink_period  <= lses_pkg::FAST_PERIOD_RST;
			regs_q.flash_period       <= lses_pkg::FLASH_PERIOD_RST;
			regs_q.flash_count        <= lses_pkg::FLASH_COUNT_RST;
			regs_q.double_blink_time  <= lses_pkg::DOUBLE_TIME_RST;
			regs_q.double_blink_pause <= lses_pkg::DOUBLE_PAUSE_RST;
			regs_q.glow_step_period   <= lses_pkg::GLOW_PERIOD_RST;
			regs_q.run_step_period    <= lses_pkg::RUN_PERIOD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				lses_pkg::CFG_BLINK_PERIOD: regs_q.blink_period <= wr_data;
				lses_pkg::CFG_FAST_PERIOD:  regs_q.fast_blink_period <= wr_data;
				lses_pkg::CFG_FLASH_PERIOD: regs_q.flash_period <= wr_data;
				lses_pkg::CFG_FLASH_COUNT:
					regs_q.flash_count <= wr_data[lses_pkg::CNT_W-1:0];
				lses_pkg::CFG_DOUBLE_TIME:  regs_q.double_blink_time <= wr_data;
				lses_pkg::CFG_DOUBLE_PAUSE: regs_q.double_blink_pause <= wr_data;
				lses_pkg::CFG_GLOW_PERIOD:  regs_q.glow_step_period <= wr_data;
				lses_pkg::CFG_RUN_PERIOD:   regs_q.run_step_period <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lses_step.sv
// Effect state and one-step update logic of the LED strip effect sequencer.
`default_nettype none

module lses_step #(
	parameter int unsigned LED_MAX     = lses_pkg::LED_MAX_DEF,
	parameter int unsigned GLOW_LEVELS = lses_pkg::GLOW_LEVELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_vld,
	input  wire lses_pkg::in_item_t  item,
	input  wire lses_pkg::cfg_regs_t cfg,
	output logic                     res_vld,
	output lses_pkg::res_t           res,
	output lses_pkg::stat_t          stat
);

	localparam int unsigned LEN_W   = lses_pkg::LEN_W;
	localparam int unsigned PH_W    = lses_pkg::PHASE_W;
	localparam int unsigned EL_W    = lses_pkg::ELAPSED_W;
	localparam int unsigned COLOR_W = lses_pkg::COLOR_W;
	localparam int unsigned FX_W    = lses_pkg::FX_W;
	localparam int unsigned LVL_W   = lses_pkg::LEVEL_W;

	localparam logic [LEN_W-1:0] LED_MAX_V = LEN_W'(LED_MAX);
	localparam logic [LEN_W-1:0] GLOW_V    = LEN_W'(GLOW_LEVELS);
	localparam logic [LEN_W-1:0] ONE_V     = LEN_W'(1);

	// Sequencer state
	logic [FX_W-1:0]    act_q, prev_q;
	logic [PH_W-1:0]    phase_q;
	logic [LEN_W-1:0]   pol_q, total_q;
	logic [COLOR_W-1:0] c1_q, c2_q, sc1_q, sc2_q;
	logic [EL_W-1:0]    elapsed_q;

	logic [FX_W-1:0]    act_d, prev_d;
	logic [PH_W-1:0]    phase_d;
	logic [LEN_W-1:0]   pol_d, total_d;
	logic [COLOR_W-1:0] c1_d, c2_d, sc1_d, sc2_d;
	logic [EL_W-1:0]    elapsed_d;

	// Timer helpers
	logic [EL_W-1:0]               el_inc;
	logic [lses_pkg::PERIOD_W-1:0] period;
	logic                          fired;
	logic [PH_W-1:0]               ph_inc;
	logic [LEN_W:0]                pol_inc;
	logic [LEN_W-1:0]              pol_dec, last_pix, len_clamp;
	logic [LVL_W-1:0]              level;

	assign stat.effect = act_q;
	assign stat.total  = total_q;

	assign el_inc  = elapsed_q[EL_W-1] ? elapsed_q : elapsed_q + EL_W'(1);
	assign ph_inc  = phase_q + PH_W'(1);
	assign pol_inc = {1'b0, pol_q} + (LEN_W+1)'(1);
	assign pol_dec = pol_q - ONE_V;
	assign last_pix = total_q - ONE_V;
	assign level   = (pol_q > GLOW_V) ? LVL_W'(GLOW_LEVELS) : pol_q[LVL_W-1:0];

	// Period that the active effect compares against
	always_comb begin
		case (act_q)
			lses_pkg::FX_BLINK:  period = cfg.blink_period;
			lses_pkg::FX_FAST:   period = cfg.fast_blink_period;
			lses_pkg::FX_FLASH:  period = cfg.flash_period;
			lses_pkg::FX_DOUBLE: period = (phase_q > PH_W'(2)) ? cfg.double_blink_pause
			                                                    : cfg.double_blink_time;
			lses_pkg::FX_GLOW:   period = cfg.glow_step_period;
			default:             period = cfg.run_step_period;
		endcase
	end

	assign fired = el_inc > {1'b0, period};

	// Strip length clamp
	always_comb begin
		if (item.strip_length == '0) begin
			len_clamp = ONE_V;
		end else if (item.strip_length > LED_MAX_V) begin
			len_clamp = LED_MAX_V;
		end else begin
			len_clamp = item.strip_length;
		end
	end

	// Next state and frame for one item
	always_comb begin
		act_d     = act_q;
		prev_d    = prev_q;
		phase_d   = phase_q;
		pol_d     = pol_q;
		total_d   = total_q;
		c1_d      = c1_q;
		c2_d      = c2_q;
		sc1_d     = sc1_q;
		sc2_d     = sc2_q;
		elapsed_d = elapsed_q;
		res_vld   = 1'b0;
		res.frame.frame_kind  = lses_pkg::KIND_FILL;
		res.frame.frame_color = c1_q;
		res.frame.pixel_index = '0;
		res.glow  = 1'b0;
		res.level = level;

		if (item_vld) begin
			case (item.req_type)
				lses_pkg::REQ_TICK: begin
					elapsed_d = el_inc;
					case (act_q) inside
						lses_pkg::FX_IDLE, lses_pkg::FX_FILL: begin
							if (phase_q == '0) begin
								phase_d = PH_W'(1);
								res_vld = 1'b1;
								res.frame.frame_color =
									(act_q == lses_pkg::FX_IDLE) ? '0 : c1_q;
							end
						end
						lses_pkg::FX_BLINK, lses_pkg::FX_FAST: begin
							if (fired) begin
								elapsed_d = '0;
								res_vld   = 1'b1;
								if (phase_q == '0) begin
									phase_d = PH_W'(1);
								end else begin
									phase_d = '0;
									res.frame.frame_color = c2_q;
								end
							end
						end
						lses_pkg::FX_FLASH: begin
							if (fired) begin
								elapsed_d = '0;
								res_vld   = 1'b1;
								res.frame.frame_color = phase_q[0] ? c2_q : c1_q;
								// Count done: restore effect and both colors
								if (ph_inc == {cfg.flash_count, 1'b0}) begin
									act_d   = prev_q;
									c1_d    = sc1_q;
									c2_d    = sc2_q;
									phase_d = '0;
								end else begin
									phase_d = ph_inc;
								end
							end
						end
						lses_pkg::FX_DOUBLE: begin
							if (phase_q == '0) begin
								res_vld = 1'b1;
								if (fired) begin
									elapsed_d = '0;
									phase_d   = PH_W'(1);
									res.frame.frame_color = c2_q;
								end
							end else if (phase_q == PH_W'(1) || phase_q == PH_W'(2)) begin
								if (fired) begin
									elapsed_d = '0;
									phase_d   = ph_inc;
									res_vld   = 1'b1;
									res.frame.frame_color =
										(ph_inc == PH_W'(2)) ? c1_q : c2_q;
								end
							end else if (fired) begin
								elapsed_d = '0;
								phase_d   = '0;
							end
						end
						lses_pkg::FX_GLOW: begin
							if (phase_q == '0) begin
								phase_d = PH_W'(1);
							end else if (fired) begin
								elapsed_d = '0;
								if (phase_q == PH_W'(1)) begin
									// Rising
									if (pol_q < GLOW_V) begin
										res_vld  = 1'b1;
										res.glow = 1'b1;
										pol_d    = pol_inc[LEN_W-1:0];
									end else begin
										phase_d = PH_W'(2);
									end
								end else if (pol_q != '0) begin
									// Falling
									res_vld  = 1'b1;
									res.glow = 1'b1;
									pol_d    = pol_dec;
								end else begin
									phase_d = '0;
								end
							end
						end
						lses_pkg::FX_FWD, lses_pkg::FX_BACK, lses_pkg::FX_PONG: begin
							if (phase_q == '0) begin
								pol_d   = (act_q == lses_pkg::FX_BACK) ? last_pix : '0;
								phase_d = PH_W'(1);
							end else if (fired) begin
								elapsed_d = '0;
								res_vld   = 1'b1;
								res.frame.frame_kind  = lses_pkg::KIND_PIXEL;
								res.frame.pixel_index = pol_q[lses_pkg::PIX_W-1:0];
								if (act_q == lses_pkg::FX_FWD) begin
									pol_d = (pol_inc >= {1'b0, total_q}) ? '0
									                                    : pol_inc[LEN_W-1:0];
								end else if (act_q == lses_pkg::FX_BACK) begin
									pol_d = (pol_q == '0) ? last_pix : pol_dec;
								end else if (phase_q == PH_W'(1)) begin
									// Ping-pong outbound
									if (pol_inc >= {1'b0, total_q}) begin
										pol_d   = last_pix;
										phase_d = PH_W'(2);
									end else begin
										pol_d = pol_inc[LEN_W-1:0];
									end
								end else begin
									// Ping-pong return
									if (pol_q == '0) begin
										phase_d = PH_W'(1);
									end else begin
										pol_d = pol_dec;
									end
								end
							end
						end
						default: ;
					endcase
				end
				lses_pkg::REQ_EFFECT: begin
					prev_d  = act_q;
					act_d   = item.effect_code;
					phase_d = '0;
					pol_d   = '0;
				end
				lses_pkg::REQ_COLOR1: begin
					sc1_d = c1_q;
					c1_d  = item.color_value;
				end
				lses_pkg::REQ_COLOR2: begin
					sc2_d = c2_q;
					c2_d  = item.color_value;
				end
				lses_pkg::REQ_LENGTH: begin
					total_d = len_clamp;
					phase_d = '0;
					pol_d   = '0;
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= lses_pkg::FX_IDLE;
			prev_q    <= lses_pkg::FX_IDLE;
			phase_q   <= '0;
			pol_q     <= '0;
			total_q   <= LED_MAX_V;
			c1_q      <= '0;
			c2_q      <= '0;
			sc1_q     <= '0;
			sc2_q     <= '0;
			elapsed_q <= '0;
		end else begin
			act_q     <= act_d;
			prev_q    <= prev_d;
			phase_q   <= phase_d;
			pol_q     <= pol_d;
			total_q   <= total_d;
			c1_q      <= c1_d;
			c2_q      <= c2_d;
			sc1_q     <= sc1_d;
			sc2_q     <= sc2_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lses_scale.sv
// Glow brightness scaling: each channel of a glow frame becomes floor(c * level / GLOW_LEVELS).
`default_nettype none

module lses_scale #(
	parameter int unsigned GLOW_LEVELS = lses_pkg::GLOW_LEVELS_DEF
) (
	input  wire lses_pkg::res_t  res,
	output lses_pkg::out_item_t  frame
);

	localparam int unsigned CH_W   = lses_pkg::CHAN_W;
	localparam int unsigned FACT_W = lses_pkg::FACT_W;
	localparam int unsigned SHIFT  = lses_pkg::SCALE_SHIFT;
	localparam int unsigned LVL_N  = lses_pkg::LEVEL_N;
	localparam int unsigned NCH    = lses_pkg::COLOR_W / CH_W;
	localparam int unsigned PROD_W = CH_W + FACT_W;

	// Factor table: ceil(L * 2^SHIFT / GLOW_LEVELS); exact for 8-bit channels
	logic [FACT_W-1:0] scale_tbl [LVL_N];
	logic [FACT_W-1:0] fact;
	logic [lses_pkg::COLOR_W-1:0] scaled;

	for (genvar i = 0; i < LVL_N; i++) begin : g_tbl
		localparam longint unsigned Entry =
			((longint'(i) * (longint'(1) << SHIFT)) + GLOW_LEVELS - 1) / GLOW_LEVELS;
		assign scale_tbl[i] = FACT_W'(Entry);
	end

	assign fact = scale_tbl[res.level];

	// One multiply per channel, then drop the fraction
	for (genvar c = 0; c < NCH; c++) begin : g_ch
		logic [PROD_W-1:0] prod;
		assign prod = PROD_W'(res.frame.frame_color[c*CH_W +: CH_W]) * PROD_W'(fact);
		assign scaled[c*CH_W +: CH_W] = prod[SHIFT +: CH_W];
	end

	assign frame.frame_kind  = res.frame.frame_kind;
	assign frame.pixel_index = res.frame.pixel_index;
	assign frame.frame_color = res.glow ? scaled : res.frame.frame_color;

endmodule

`default_nettype wire

FILE: hw/rtl/led_strip_effect_sequencer.sv
// Top level of the LED strip effect sequencer.
// Pipeline: three register stages: the input register, the step logic into the frame register,
// and glow scaling into the output register.
// Throughput: one item per cycle; the whole pipeline holds only while a result is stalled.
// Reset: asynchronous, active low; config takes its defaults, effect idle, colors black,
// strip length LED_MAX, pipeline empty. No clearing pass.
`default_nettype none

module led_strip_effect_sequencer #(
	parameter int unsigned LED_MAX     = lses_pkg::LED_MAX_DEF,
	parameter int unsigned GLOW_LEVELS = lses_pkg::GLOW_LEVELS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire lses_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output lses_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lses_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lses_pkg::PERIOD_W-1:0]      cfg_data
);

	lses_pkg::cfg_regs_t  cfg;
	lses_pkg::in_item_t   item_s1;
	lses_pkg::res_t       res, res_s2;
	lses_pkg::stat_t      stat;
	lses_pkg::out_item_t  scaled, out_q;
	logic                 valid_s1, valid_s2, out_valid_q;
	logic                 adv, res_vld;

	// Pipeline moves unless a finished transaction is stalled at the output
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lses_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	lses_step #(
		.LED_MAX     (LED_MAX),
		.GLOW_LEVELS (GLOW_LEVELS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (valid_s1 && adv),
		.item     (item_s1),
		.cfg      (cfg),
		.res_vld  (res_vld),
		.res      (res),
		.stat     (stat)
	);

	lses_scale #(
		.GLOW_LEVELS (GLOW_LEVELS)
	) u_scale (
		.res   (res_s2),
		.frame (scaled)
	);

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1 && res_vld;
			out_valid_q <= valid_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				item_s1 <= in_data;
			end
			if (valid_s1 && res_vld) begin
				res_s2 <= res;
			end
			if (valid_s2) begin
				out_q <= scaled;
			end
		end
	end

`ifndef SYNTHESIS
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.total >= lses_pkg::LEN_W'(1) &&
		stat.total <= lses_pkg::LEN_W'(LED_MAX))
		else $error("strip length out of range");

	a_fill_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_kind == lses_pkg::KIND_FILL |->
		out_data.pixel_index == '0)
		else $error("fill frame with nonzero pixel index");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s2))
		else $error("result without a frame in flight");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_led_strip_effect_sequencer.sv
// Self-checking testbench for the LED strip effect sequencer: frame prediction and scoreboard.
`timescale 1ns / 1ps

module tb_led_strip_effect_sequencer;
	import lses_pkg::*;

	localparam int unsigned STRIP_MAX     = LED_MAX_DEF;
	localparam int unsigned GLOW_STEPS    = GLOW_LEVELS_DEF;
	localparam int unsigned SETTLE_CYCLES = 8;    // three-stage pipeline plus margin
	localparam int unsigned REPORT_CAP    = 60;
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
	localparam logic [FX_W-1:0]  FX_UNKNOWN_TOP = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0] cfg_data = '0;

	led_strip_effect_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sequencer shadow state
	cfg_regs_t timing;
	logic [FX_W-1:0]      fx_active, fx_prev;
	logic [PHASE_W-1:0]   seq_phase;
	logic [LEN_W-1:0]     pos_level;
	logic [COLOR_W-1:0]   color_a, color_b, color_a_saved, color_b_saved;
	logic [ELAPSED_W-1:0] ms_elapsed;
	logic [LEN_W-1:0]     strip_len;

	out_item_t frames_due[$];
	int mismatch_count = 0;
	int requests_sent = 0;
	int frames_checked = 0;
	int timing_sets = 0;
	bit gaps_on = 1'b1;
	int burst_left = 8;

	task automatic reset_shadow();
		timing.blink_period       = BLINK_PERIOD_RST;
		timing.fast_blink_period  = FAST_PERIOD_RST;
		timing.flash_period       = FLASH_PERIOD_RST;
		timing.flash_count        = FLASH_COUNT_RST;
		timing.double_blink_time  = DOUBLE_TIME_RST;
		timing.double_blink_pause = DOUBLE_PAUSE_RST;
		timing.glow_step_period   = GLOW_PERIOD_RST;
		timing.run_step_period    = RUN_PERIOD_RST;
		fx_active = FX_IDLE;
		fx_prev = FX_IDLE;
		seq_phase = '0;
		pos_level = '0;
		color_a = '0;
		color_b = '0;
		color_a_saved = '0;
		color_b_saved = '0;
		ms_elapsed = '0;
		strip_len = LEN_W'(STRIP_MAX);
	endtask

	// Timed action: fires once the ms count passes the period, then restarts it
	function automatic bit period_elapsed(logic [PERIOD_W-1:0] period);
		if (ms_elapsed > {1'b0, period}) begin
			ms_elapsed = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic out_item_t fill_frame(logic [COLOR_W-1:0] color);
		out_item_t fr;
		fr.frame_kind = KIND_FILL;
		fr.frame_color = color;
		fr.pixel_index = '0;
		return fr;
	endfunction

	function automatic out_item_t pixel_frame(int unsigned idx);
		out_item_t fr;
		fr.frame_kind = KIND_PIXEL;
		fr.frame_color = color_a;
		fr.pixel_index = PIX_W'(idx);
		return fr;
	endfunction

	// Exact floor(component * level / levels) per channel
	function automatic logic [COLOR_W-1:0] glow_scale(logic [COLOR_W-1:0] c, int unsigned lvl);
		int unsigned r, g, b;
		r = c[23:16] * lvl / GLOW_STEPS;
		g = c[15:8] * lvl / GLOW_STEPS;
		b = c[7:0] * lvl / GLOW_STEPS;
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	function automatic bit blink_frame(logic [PERIOD_W-1:0] period, output out_item_t fr);
		if (!period_elapsed(period)) return 1'b0;
		if (seq_phase == 0) begin
			seq_phase = 1;
			fr = fill_frame(color_a);
		end else begin
			seq_phase = 0;
			fr = fill_frame(color_b);
		end
		return 1'b1;
	endfunction

	// One millisecond step of the active effect
	function automatic bit tick_frame(output out_item_t fr);
		int unsigned p;
		fr = '0;
		if (ms_elapsed < 17'h10000) ms_elapsed++;
		case (fx_active)
			FX_IDLE, FX_FILL: begin
				if (seq_phase == 0) begin
					seq_phase = 1;
					fr = fill_frame(fx_active == FX_IDLE ? '0 : color_a);
					return 1'b1;
				end
				return 1'b0;
			end
			FX_BLINK: return blink_frame(timing.blink_period, fr);
			FX_FAST: return blink_frame(timing.fast_blink_period, fr);
			FX_FLASH: begin
				if (!period_elapsed(timing.flash_period)) return 1'b0;
				fr = fill_frame(seq_phase[0] ? color_b : color_a);
				seq_phase = seq_phase + 1'b1;
				// count of zero wraps the 9-bit phase: 512 toggles
				if (seq_phase == {timing.flash_count, 1'b0}) begin
					fx_active = fx_prev;
					color_a = color_a_saved;
					color_b = color_b_saved;
					seq_phase = '0;
				end
				return 1'b1;
			end
			FX_DOUBLE: begin
				if (seq_phase == 0) begin
					if (period_elapsed(timing.double_blink_time)) begin
						seq_phase = 1;
						fr = fill_frame(color_b);
					end else begin
						fr = fill_frame(color_a);
					end
					return 1'b1;
				end
				if (seq_phase == 1 || seq_phase == 2) begin
					if (!period_elapsed(timing.double_blink_time)) return 1'b0;
					seq_phase = seq_phase + 1'b1;
					fr = fill_frame(seq_phase == 2 ? color_a : color_b);
					return 1'b1;
				end
				if (period_elapsed(timing.double_blink_pause)) seq_phase = '0;
				return 1'b0;
			end
			FX_GLOW: begin
				if (seq_phase == 0) begin
					seq_phase = 1;
					return 1'b0;
				end
				if (!period_elapsed(timing.glow_step_period)) return 1'b0;
				if (seq_phase == 1) begin
					if (pos_level < GLOW_STEPS) begin
						fr = fill_frame(glow_scale(color_a, pos_level));
						pos_level++;
						return 1'b1;
					end
					seq_phase = 2;
					return 1'b0;
				end
				if (pos_level > 0) begin
					p = (pos_level > GLOW_STEPS) ? GLOW_STEPS : pos_level;
					fr = fill_frame(glow_scale(color_a, p));
					pos_level--;
					return 1'b1;
				end
				seq_phase = '0;
				return 1'b0;
			end
			FX_FWD, FX_BACK, FX_PONG: begin
				if (seq_phase == 0) begin
					pos_level = (fx_active == FX_BACK) ? strip_len - 1'b1 : '0;
					seq_phase = 1;
					return 1'b0;
				end
				if (!period_elapsed(timing.run_step_period)) return 1'b0;
				p = pos_level;
				fr = pixel_frame(p);
				if (fx_active == FX_FWD) begin
					pos_level = (p + 1 >= strip_len) ? '0 : LEN_W'(p + 1);
				end else if (fx_active == FX_BACK) begin
					pos_level = (p == 0) ? strip_len - 1'b1 : LEN_W'(p - 1);
				end else if (seq_phase == 1) begin
					if (p + 1 >= strip_len) begin
						pos_level = strip_len - 1'b1;
						seq_phase = 2;
					end else begin
						pos_level = LEN_W'(p + 1);
					end
				end else begin
					if (p == 0) begin
						pos_level = '0;
						seq_phase = 1;
					end else begin
						pos_level = LEN_W'(p - 1);
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Apply one request to the shadow state; returns 1 when it yields a frame
	function automatic bit predict_frame(input in_item_t it, output out_item_t fr);
		int unsigned len;
		fr = '0;
		case (it.req_type)
			REQ_TICK: return tick_frame(fr);
			REQ_EFFECT: begin
				fx_prev = fx_active;
				fx_active = it.effect_code;
				seq_phase = '0;
				pos_level = '0;
			end
			REQ_COLOR1: begin
				color_a_saved = color_a;
				color_a = it.color_value;
			end
			REQ_COLOR2: begin
				color_b_saved = color_b;
				color_b = it.color_value;
			end
			REQ_LENGTH: begin
				len = it.strip_length;
				if (len == 0) len = 1;
				if (len > STRIP_MAX) len = STRIP_MAX;
				strip_len = LEN_W'(len);
				seq_phase = '0;
				pos_level = '0;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Request with random content in the fields its type does not use
	function automatic in_item_t noisy_item(logic [REQ_W-1:0] kind);
		in_item_t it;
		it.req_type = kind;
		it.effect_code = FX_W'($urandom);
		it.color_value = COLOR_W'($urandom);
		it.strip_length = LEN_W'($urandom);
		return it;
	endfunction

	// Send one request; valid stays high into the next call unless a gap is due
	task automatic send_request(input in_item_t it);
		out_item_t fr;
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		if (predict_frame(it, fr)) frames_due.push_back(fr);
		@(negedge clk);
		if (gaps_on) begin
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				                                         : $urandom_range(1, 24);
			end
		end
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_request(noisy_item(REQ_TICK));
	endtask

	task automatic send_effect(logic [FX_W-1:0] code);
		in_item_t it;
		it = noisy_item(REQ_EFFECT);
		it.effect_code = code;
		send_request(it);
	endtask

	task automatic send_color(logic [REQ_W-1:0] which, logic [COLOR_W-1:0] color);
		in_item_t it;
		it = noisy_item(which);
		it.color_value = color;
		send_request(it);
	endtask

	task automatic send_length(logic [LEN_W-1:0] len);
		in_item_t it;
		it = noisy_item(REQ_LENGTH);
		it.strip_length = len;
		send_request(it);
	endtask

	// Wait for every expected frame, then let the pipeline empty
	task automatic settle_pipeline();
		in_valid = 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all eight timing registers; only called with the block idle
	task automatic load_timing(cfg_regs_t v);
		logic [PERIOD_W-1:0] d;
		cfg_valid = 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index = CFG_IDX_W'(i);
			case (cfg_index)
				CFG_BLINK_PERIOD: d = v.blink_period;
				CFG_FAST_PERIOD:  d = v.fast_blink_period;
				CFG_FLASH_PERIOD: d = v.flash_period;
				CFG_FLASH_COUNT:  d = {8'($urandom), v.flash_count};
				CFG_DOUBLE_TIME:  d = v.double_blink_time;
				CFG_DOUBLE_PAUSE: d = v.double_blink_pause;
				CFG_GLOW_PERIOD:  d = v.glow_step_period;
				default:          d = v.run_step_period;
			endcase
			cfg_data = d;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid = 1'b0;
		timing = v;
		timing_sets++;
	endtask

	function automatic cfg_regs_t random_timing(int unsigned hi, logic [CNT_W-1:0] cnt);
		cfg_regs_t v;
		v.blink_period       = PERIOD_W'($urandom_range(0, hi));
		v.fast_blink_period  = PERIOD_W'($urandom_range(0, hi));
		v.flash_period       = PERIOD_W'($urandom_range(0, hi));
		v.flash_count        = cnt;
		v.double_blink_time  = PERIOD_W'($urandom_range(0, hi));
		v.double_blink_pause = PERIOD_W'($urandom_range(0, hi));
		v.glow_step_period   = PERIOD_W'($urandom_range(0, hi));
		v.run_step_period    = PERIOD_W'($urandom_range(0, hi));
		return v;
	endfunction

	// Mostly ticks, with effect, color and length changes and spare request types in between
	function automatic in_item_t random_request();
		in_item_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 82) begin
			it = noisy_item(REQ_TICK);
		end else if (r < 86) begin
			it = noisy_item(REQ_EFFECT);
			if ($urandom_range(0, 9) != 0) it.effect_code = FX_W'($urandom_range(0, FX_PONG));
		end else if (r < 94) begin
			it = noisy_item(r < 90 ? REQ_COLOR1 : REQ_COLOR2);
			if ($urandom_range(0, 9) == 0) it.color_value = $urandom_range(0, 1) ? '1 : '0;
		end else if (r < 98) begin
			it = noisy_item(REQ_LENGTH);
			if ($urandom_range(0, 3) != 0) it.strip_length = LEN_W'($urandom_range(1, 12));
		end else begin
			it = noisy_item(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)));
		end
		return it;
	endfunction

	// Extremes of every field, each effect code and the odd request types
	task automatic test_directed();
		send_ticks(2);
		send_color(REQ_COLOR1, 24'hFFFFFF);
		send_color(REQ_COLOR2, 24'h000000);
		send_effect(FX_FILL);
		send_ticks(2);
		send_effect(FX_DOUBLE);
		send_ticks(2);
		send_effect(FX_UNKNOWN_TOP);
		send_ticks(1);
		for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++) send_request(noisy_item(REQ_W'(k)));
		send_length(11'd0);
		send_effect(FX_FWD);
		send_length(11'd2047);
		send_length(LEN_W'(STRIP_MAX));
		send_effect(FX_BACK);
		send_ticks(1);
		send_effect(FX_PONG);
		send_effect(FX_GLOW);
		send_ticks(1);
		send_effect(FX_FLASH);
		send_effect(FX_BLINK);
		send_effect(FX_FAST);
		send_effect(FX_IDLE);
		send_ticks(1);
	endtask

	// Full rise and fall of the glow, both turns included
	task automatic test_glow_ramp();
		settle_pipeline();
		load_timing(random_timing(0, 8'd1));
		send_color(REQ_COLOR1, 24'hFFFFFF);
		send_effect(FX_GLOW);
		send_ticks(206);
		send_color(REQ_COLOR1, COLOR_W'($urandom));
		send_effect(FX_GLOW);
		send_ticks(40);
	endtask

	// Running pixel on short strips so every wrap and bounce shows up
	task automatic test_run_wrap();
		logic [FX_W-1:0] runners[3];
		int unsigned lens[3];
		runners = '{FX_FWD, FX_BACK, FX_PONG};
		lens = '{1, 2, 5};
		settle_pipeline();
		load_timing(random_timing(1, 8'd2));
		send_color(REQ_COLOR1, COLOR_W'($urandom));
		foreach (lens[i]) begin
			send_length(LEN_W'(lens[i]));
			foreach (runners[j]) begin
				send_effect(runners[j]);
				send_ticks(4 * lens[i] + 6);
			end
		end
	endtask

	// Flash then fall back to the previous effect and colors
	task automatic test_flash_restore();
		cfg_regs_t v;
		settle_pipeline();
		v = random_timing(0, 8'd2);
		v.flash_period = 16'd1;
		load_timing(v);
		send_color(REQ_COLOR1, COLOR_W'($urandom));
		send_color(REQ_COLOR1, COLOR_W'($urandom));
		send_color(REQ_COLOR2, COLOR_W'($urandom));
		send_color(REQ_COLOR2, COLOR_W'($urandom));
		send_effect(FX_BLINK);
		send_effect(FX_FLASH);
		send_ticks(14);
	endtask

	// Flash count of zero runs 512 toggles before restoring
	task automatic test_flash_zero_count();
		settle_pipeline();
		load_timing(random_timing(0, 8'd0));
		send_effect(FX_PONG);
		send_effect(FX_FLASH);
		send_ticks(520);
	endtask

	// Random traffic under several timing settings
	task automatic test_random_phases();
		int unsigned his[5];
		int unsigned lens[5];
		logic [CNT_W-1:0] cnts[5];
		his = '{2, 6, 4, 12, 65535};
		cnts = '{8'd1, 8'd255, CNT_W'($urandom_range(0, 4)), 8'd3, 8'd255};
		lens = '{120, 120, 120, 120, 60};
		foreach (his[i]) begin
			settle_pipeline();
			load_timing(random_timing(his[i], cnts[i]));
			repeat (lens[i]) send_request(random_request());
		end
	endtask

	// Longest blink period stays quiet over back-to-back ticks
	task automatic test_long_period();
		cfg_regs_t v;
		settle_pipeline();
		v = random_timing(20, 8'd3);
		v.blink_period = 16'hFFFF;
		load_timing(v);
		gaps_on = 1'b0;
		send_effect(FX_BLINK);
		send_ticks(30);
		gaps_on = 1'b1;
	endtask

	// Receiver stalls in stretches of differing density
	int stall_span = 0;
	int stall_mode = 0;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 200);
		end
		stall_span--;
		case (stall_mode)
			0: out_stall = 1'b0;
			1: out_stall = ($urandom_range(0, 3) == 0);
			2: out_stall = ($urandom_range(0, 3) != 0);
			default: out_stall = stall_span[2];
		endcase
	end

	function automatic void check_field(string name, logic [COLOR_W-1:0] want,
	                                    logic [COLOR_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	// Frame scoreboard: each accepted transaction against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: unexpected frame, expected none, got %h", $time, out_data);
			end else begin
				want = frames_due.pop_front();
				frames_checked++;
				check_field("frame_kind", COLOR_W'(want.frame_kind), COLOR_W'(out_data.frame_kind));
				check_field("frame_color", want.frame_color, out_data.frame_color);
				check_field("pixel_index", COLOR_W'(want.pixel_index),
				            COLOR_W'(out_data.pixel_index));
			end
		end
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("Timeout with %0d frames outstanding", frames_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		reset_shadow();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_glow_ramp();
		test_run_wrap();
		test_flash_restore();
		test_flash_zero_count();
		test_random_phases();
		test_long_period();
		settle_pipeline();
		$display("Sent %0d requests under %0d timing settings, checked %0d frames",
		         requests_sent, timing_sets, frames_checked);
		$display("All ten effects, flash restore, glow turns, strip wraps and the longest period");
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/lses_pkg.sv
hw/rtl/lses_cfg.sv
hw/rtl/lses_step.sv
hw/rtl/lses_scale.sv
hw/rtl/led_strip_effect_sequencer.sv
sim/tb_led_strip_effect_sequencer.sv
